### design/gamma_correct_bilinear_scaler_macros.svh
// assertion macros for the gamma-correct bilinear scaler
// expects clk_i and rst_ni in the scope of each use
`ifndef GAMMA_CORRECT_BILINEAR_SCALER_MACROS_SVH
`define GAMMA_CORRECT_BILINEAR_SCALER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GCBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gcbs assertion failed");
`define GCBS_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("gcbs forbidden condition");
`else
`define GCBS_ASSERT(label, prop)
`define GCBS_NEVER(label, expr)
`endif
`endif

### design/gcbs_pkg.sv
// shared types, constants and gamma tables of the bilinear scaler
// no dependencies
package gcbs_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int WORD_W     = 32;
  localparam int POS_W      = 7;
  localparam int SIZE_W     = 8;
  localparam int PROD_W     = POS_W + SIZE_W;
  localparam int Q_W        = PROD_W + 8;
  localparam int IP_W       = Q_W - 8 + 1;
  localparam int LIN_W      = 12;
  localparam int H_W        = 21;
  localparam int V_W        = 28;
  localparam int DIV_STEPS  = Q_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_CROP_X = 3'd2;
  localparam logic [2:0] REG_CROP_Y = 3'd3;
  localparam logic [2:0] REG_CROP_W = 3'd4;
  localparam logic [2:0] REG_CROP_H = 3'd5;
  localparam logic [2:0] REG_DST_W  = 3'd6;
  localparam logic [2:0] REG_DST_H  = 3'd7;

  typedef struct packed {
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [POS_W-1:0]  crop_x;
    logic [POS_W-1:0]  crop_y;
    logic [SIZE_W-1:0] crop_w;
    logic [SIZE_W-1:0] crop_h;
    logic [SIZE_W-1:0] dst_w;
    logic [SIZE_W-1:0] dst_h;
  } cfg_t;

  typedef struct packed {
    logic       load_we;
    logic       div_start;
    logic       div_step;
    logic       pos_calc;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       hblend;
    logic       vblend;
    logic       out_load;
  } cmd_t;

  typedef logic [255:0][LIN_W-1:0] fwd_rom_t;
  typedef logic [4095:0][7:0]      inv_rom_t;

  function automatic logic [SIZE_W-1:0] nz8(input logic [SIZE_W-1:0] v);
    return (v == '0) ? SIZE_W'(1) : v;
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] y);
    logic [63:0] y2;
    y2 = qmul(y, y);
    return qmul(qmul(y2, y2), y);
  endfunction

  function automatic logic [63:0] root5(input logic [63:0] a);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow5(mid) <= a) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  // srgb decode of num/255 in q30
  function automatic logic [63:0] decode_255(input logic [63:0] num);
    logic [63:0] t;
    logic [63:0] t2;
    if (num * 64'd100000 <= 64'd1031475) return ((num << 30) * 64'd100) / 64'd329460;
    t  = ((64'd1000 * num + 64'd14025) << 30) / 64'd269025;
    t2 = qmul(t, t);
    return qmul(t2, root5(t2));
  endfunction

  // srgb decode of num/510 in q30
  function automatic logic [63:0] decode_510(input logic [63:0] num);
    logic [63:0] t;
    logic [63:0] t2;
    if (num * 64'd100000 <= 64'd2062950) return ((num << 30) * 64'd100) / 64'd658920;
    t  = ((64'd1000 * num + 64'd28050) << 30) / 64'd538050;
    t2 = qmul(t, t);
    return qmul(t2, root5(t2));
  endfunction

  function automatic fwd_rom_t build_fwd();
    fwd_rom_t r;
    for (int c = 0; c < 256; c++) begin
      r[c] = LIN_W'((decode_255(64'(c)) * 64'd4095 + (64'd1 << 29)) >> 30);
    end
    return r;
  endfunction

  // round-to-nearest encode: count of code thresholds at or below the value
  function automatic inv_rom_t build_inv();
    inv_rom_t    r;
    logic [63:0] thr [255];
    int          n;
    for (int c = 1; c < 256; c++) begin
      thr[c-1] = decode_510(64'(2 * c - 1)) * 64'd4095;
    end
    n = 0;
    for (int v = 0; v < 4096; v++) begin
      while (n < 255 && ((64'(v) << 30) >= thr[n])) n++;
      r[v] = 8'(n);
    end
    return r;
  endfunction

  localparam fwd_rom_t FWD_ROM = build_fwd();
  localparam inv_rom_t INV_ROM = build_inv();

endpackage

### design/gcbs_ram.sv
// generic single-port ram with registered read
// no dependencies
module gcbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### design/gcbs_div.sv
// bit-serial restoring divider for the source position, one quotient bit a step
// depends on gcbs_pkg
module gcbs_div import gcbs_pkg::*; (
  input  logic              clk_i,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic [Q_W-1:0]    quot_o
);

  logic [Q_W-1:0]    num_q, num_d;
  logic [Q_W-1:0]    quot_q, quot_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] den_q, den_d;
  logic [SIZE_W:0]   trial;
  logic              bit_ok;

  always_comb begin
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, num_q[Q_W-1]};
    bit_ok = (trial >= {1'b0, den_q});
    if (start_i) begin
      num_d  = {dividend_i, 8'd0};
      quot_d = '0;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (step_i) begin
      num_d  = {num_q[Q_W-2:0], 1'b0};
      quot_d = {quot_q[Q_W-2:0], bit_ok};
      rem_d  = bit_ok ? SIZE_W'(trial - {1'b0, den_q}) : SIZE_W'(trial);
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign quot_o = quot_q;

endmodule

### design/gcbs_ctrl.sv
// sequencer of the scaler: handshakes, division steps, frame reads, blend
// depends on gcbs_pkg
module gcbs_ctrl import gcbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic operation_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_POS, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
    ST_HB, ST_VB, ST_ENC
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_we   = in_valid_i && (operation_i == OP_LOAD);
        cmd_o.div_start = in_valid_i && (operation_i == OP_COMPUTE);
      end
      ST_DIV: cmd_o.div_step = 1'b1;
      ST_POS: cmd_o.pos_calc = 1'b1;
      ST_RD0: begin
        cmd_o.rd_sel = 2'd0;
      end
      ST_RD1: begin
        cmd_o.rd_sel  = 2'd1;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = 2'd0;
      end
      ST_RD2: begin
        cmd_o.rd_sel  = 2'd2;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = 2'd1;
      end
      ST_RD3: begin
        cmd_o.rd_sel  = 2'd3;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = 2'd2;
      end
      ST_RD4: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = 2'd3;
      end
      ST_HB:  cmd_o.hblend   = 1'b1;
      ST_VB:  cmd_o.vblend   = 1'b1;
      ST_ENC: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_o.out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (operation_i == OP_COMPUTE)) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_POS;
          end
        end
        ST_POS: state_q <= ST_RD0;
        ST_RD0: state_q <= ST_RD1;
        ST_RD1: state_q <= ST_RD2;
        ST_RD2: state_q <= ST_RD3;
        ST_RD3: state_q <= ST_RD4;
        ST_RD4: state_q <= ST_HB;
        ST_HB:  state_q <= ST_VB;
        ST_VB:  state_q <= ST_ENC;
        ST_ENC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/gcbs_dp.sv
// datapath: frame store, position dividers, neighbor fetch, linear-space blend
// depends on gcbs_pkg, gcbs_ram, gcbs_div
module gcbs_dp import gcbs_pkg::*; (
  input  logic              clk_i,
  input  cmd_t              cmd_i,
  input  cfg_t              cfg_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  input  logic [7:0]        in_red_i,
  input  logic [7:0]        in_green_i,
  input  logic [7:0]        in_blue_i,
  input  logic [7:0]        in_alpha_i,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic [7:0]        out_alpha_o
);

  logic [Q_W-1:0]    qx, qy;
  logic [XW-1:0]     x0_q, x1_q, x_last;
  logic [YW-1:0]     y0_q, y1_q, y_last;
  logic [7:0]        fx_q, fy_q;
  logic [IP_W-1:0]   ipx, ipy;
  logic [XW-1:0]     x0_d;
  logic [YW-1:0]     y0_d;
  logic [SIZE_W-1:0] sw, sh;
  logic [ADDR_W-1:0] ram_addr, rd_addr;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [WORD_W-1:0] pix_q [4];
  logic [H_W-1:0]    top_q [4], bot_q [4], top_d [4], bot_d [4];
  logic [V_W-1:0]    v_q [4], v_d [4];
  logic [LIN_W-1:0]  a00, a10, a01, a11;
  logic [8:0]        wx0, wy0;
  logic [LIN_W-1:0]  idx_r, idx_g, idx_b;
  logic [XW-1:0]     rx;
  logic [YW-1:0]     ry;

  gcbs_div u_div_x (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (PROD_W'(pos_x_i) * PROD_W'(nz8(cfg_i.crop_w))),
    .divisor_i  (nz8(cfg_i.dst_w)),
    .quot_o     (qx)
  );

  gcbs_div u_div_y (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (PROD_W'(pos_y_i) * PROD_W'(nz8(cfg_i.crop_h))),
    .divisor_i  (nz8(cfg_i.dst_h)),
    .quot_o     (qy)
  );

  // last valid column and row of the stored image, and the clamped integer source position
  always_comb begin
    sw     = nz8(cfg_i.src_w);
    sh     = nz8(cfg_i.src_h);
    x_last = (32'(sw) > MAX_WIDTH)  ? XW'(MAX_WIDTH - 1)  : XW'(32'(sw) - 1);
    y_last = (32'(sh) > MAX_HEIGHT) ? YW'(MAX_HEIGHT - 1) : YW'(32'(sh) - 1);
    ipx    = IP_W'(cfg_i.crop_x) + IP_W'(qx[Q_W-1:8]);
    ipy    = IP_W'(cfg_i.crop_y) + IP_W'(qy[Q_W-1:8]);
    x0_d   = (32'(ipx) > 32'(x_last)) ? x_last : XW'(ipx);
    y0_d   = (32'(ipy) > 32'(y_last)) ? y_last : YW'(ipy);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_calc) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      x1_q <= (x0_d == x_last) ? x0_d : x0_d + XW'(1);
      y1_q <= (y0_d == y_last) ? y0_d : y0_d + YW'(1);
      fx_q <= (x0_d == x_last) ? 8'd0 : qx[7:0];
      fy_q <= (y0_d == y_last) ? 8'd0 : qy[7:0];
    end
  end

  // single port: loads write at accept, computes read the four neighbors
  always_comb begin
    rx       = cmd_i.rd_sel[0] ? x1_q : x0_q;
    ry       = cmd_i.rd_sel[1] ? y1_q : y0_q;
    rd_addr  = ADDR_W'(32'(ry) * MAX_WIDTH + 32'(rx));
    ram_we   = cmd_i.load_we && (32'(pos_x_i) < MAX_WIDTH) && (32'(pos_y_i) < MAX_HEIGHT);
    ram_addr = cmd_i.load_we
             ? ADDR_W'(32'(pos_y_i) * MAX_WIDTH + 32'(pos_x_i)) : rd_addr;
    ram_wdata = {in_alpha_i, in_blue_i, in_green_i, in_red_i};
  end

  gcbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      pix_q[cmd_i.cap_sel] <= ram_rdata;
    end
  end

  // horizontal pass, lanes red green blue alpha
  always_comb begin
    wx0 = 9'd256 - {1'b0, fx_q};
    for (int ch = 0; ch < 4; ch++) begin
      if (ch < 3) begin
        a00 = FWD_ROM[pix_q[0][ch*8 +: 8]];
        a10 = FWD_ROM[pix_q[1][ch*8 +: 8]];
        a01 = FWD_ROM[pix_q[2][ch*8 +: 8]];
        a11 = FWD_ROM[pix_q[3][ch*8 +: 8]];
      end else begin
        a00 = LIN_W'(pix_q[0][31:24]);
        a10 = LIN_W'(pix_q[1][31:24]);
        a01 = LIN_W'(pix_q[2][31:24]);
        a11 = LIN_W'(pix_q[3][31:24]);
      end
      top_d[ch] = H_W'(H_W'(a00) * H_W'(wx0)) + H_W'(H_W'(a10) * H_W'(fx_q));
      bot_d[ch] = H_W'(H_W'(a01) * H_W'(wx0)) + H_W'(H_W'(a11) * H_W'(fx_q));
    end
  end

  always_comb begin
    wy0 = 9'd256 - {1'b0, fy_q};
    for (int ch = 0; ch < 4; ch++) begin
      v_d[ch] = V_W'(30'(top_q[ch]) * 30'(wy0) + 30'(bot_q[ch]) * 30'(fy_q));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 4; ch++) begin
      if (cmd_i.hblend) begin
        top_q[ch] <= top_d[ch];
        bot_q[ch] <= bot_d[ch];
      end
      if (cmd_i.vblend) begin
        v_q[ch] <= v_d[ch];
      end
    end
  end

  // round to the nearest 12-bit linear code, then encode
  assign idx_r = LIN_W'((29'(v_q[0]) + 29'd32768) >> 16);
  assign idx_g = LIN_W'((29'(v_q[1]) + 29'd32768) >> 16);
  assign idx_b = LIN_W'((29'(v_q[2]) + 29'd32768) >> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_red_o   <= INV_ROM[idx_r];
      out_green_o <= INV_ROM[idx_g];
      out_blue_o  <= INV_ROM[idx_b];
      out_alpha_o <= v_q[3][23:16];
    end
  end

endmodule

### design/gamma_correct_bilinear_scaler.sv
// gamma-correct bilinear scaler over an rgba frame store
// a compute word passes the 23-step bit-serial position divider and four reads of the
// single-port frame ram before its result shows, and a stalled output holds it back
// throughput: one load word per cycle while idle; the input stays closed while a compute word works
// reset returns control to idle and configuration to its defaults; the frame store has no reset
module gamma_correct_bilinear_scaler import gcbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  input  logic [7:0]        in_red_i,
  input  logic [7:0]        in_green_i,
  input  logic [7:0]        in_blue_i,
  input  logic [7:0]        in_alpha_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic [7:0]        out_alpha_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_wdata_i
);

`include "gamma_correct_bilinear_scaler_macros.svh"

  cfg_t cfg_q;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w  <= 8'd128;
      cfg_q.src_h  <= 8'd128;
      cfg_q.crop_x <= 7'd0;
      cfg_q.crop_y <= 7'd0;
      cfg_q.crop_w <= 8'd128;
      cfg_q.crop_h <= 8'd128;
      cfg_q.dst_w  <= 8'd128;
      cfg_q.dst_h  <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_W:  cfg_q.src_w  <= cfg_wdata_i;
        REG_SRC_H:  cfg_q.src_h  <= cfg_wdata_i;
        REG_CROP_X: cfg_q.crop_x <= cfg_wdata_i[POS_W-1:0];
        REG_CROP_Y: cfg_q.crop_y <= cfg_wdata_i[POS_W-1:0];
        REG_CROP_W: cfg_q.crop_w <= cfg_wdata_i;
        REG_CROP_H: cfg_q.crop_h <= cfg_wdata_i;
        REG_DST_W:  cfg_q.dst_w  <= cfg_wdata_i;
        REG_DST_H:  cfg_q.dst_h  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gcbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  gcbs_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .in_alpha_i  (in_alpha_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o)
  );

  // a compute word keeps the input side closed while it works
  `GCBS_ASSERT(a_busy_after_compute,
    in_valid_i && in_ready_o && (operation_i == OP_COMPUTE) |=> !in_ready_o)
  // datapath steps never overlap
  `GCBS_ASSERT(a_cmd_onehot,
    $onehot0({cmd.div_start, cmd.div_step, cmd.pos_calc, cmd.hblend, cmd.vblend, cmd.out_load}))
  // frame writes happen only at an accepted load
  `GCBS_NEVER(a_write_when_busy, cmd.load_we && !in_ready_o)

endmodule

### bench/tb_top.sv
// testbench for the gamma-correct bilinear scaler: directed table, then random load/compute words
// checked against a self-contained fixed-point predictor; depends on gcbs_pkg and the scaler rtl
module tb_top;
  import gcbs_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct {
    logic       op;
    logic [6:0] px;
    logic [6:0] py;
    pixel_t     pix;
    bit         typed;
    pixel_t     want;
  } row_t;

  typedef struct {
    logic [7:0] src_w, src_h, crop_x, crop_y, crop_w, crop_h, dst_w, dst_h;
  } scaler_cfg_t;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       operation_i = OP_LOAD;
  logic [6:0] pos_x_i = '0;
  logic [6:0] pos_y_i = '0;
  logic [7:0] in_red_i = '0, in_green_i = '0, in_blue_i = '0, in_alpha_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = REG_SRC_W;
  logic [7:0] cfg_wdata_i = '0;

  gamma_correct_bilinear_scaler dut (.*);

  always #5 clk_i = ~clk_i;

  // own copy of the block state
  logic [11:0]  lin_lut [256];
  logic [63:0]  enc_limit [255];
  logic [7:0]   enc_lut [4096];
  pixel_t       frame_copy [MAX_WIDTH*MAX_HEIGHT];
  bit           loaded [MAX_WIDTH*MAX_HEIGHT];
  scaler_cfg_t  cur_cfg;
  pixel_t       pending_pixels [$];
  pixel_t       got_exp;
  int           fail_count = 0;
  int           idle_in = 22, idle_out = 50;
  int           quiet_cycles = 0;
  int           sent = 0;

  function automatic logic [63:0] fixmul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] fifth_root(logic [63:0] a);
    logic [63:0] lo, hi, mid, sq;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      sq = fixmul(mid, mid);
      if (fixmul(fixmul(sq, sq), mid) <= a) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // srgb decode of num/den, q30
  function automatic logic [63:0] lin_q30(logic [63:0] num, logic [63:0] den);
    logic [63:0] t, t2;
    if (num * 100000 <= 4045 * den) return ((num << 30) * 100) / (1292 * den);
    t = ((1000 * num + 55 * den) << 30) / (1055 * den);
    t2 = fixmul(t, t);
    return fixmul(t2, fifth_root(t2));
  endfunction

  function automatic void build_gamma_luts();
    int n;
    for (int c = 0; c < 256; c++)
      lin_lut[c] = 12'((lin_q30(c, 255) * 4095 + (64'd1 << 29)) >> 30);
    for (int c = 1; c < 256; c++) enc_limit[c-1] = lin_q30(2 * c - 1, 510) * 4095;
    for (int v = 0; v < 4096; v++) begin
      n = 0;
      for (int c = 0; c < 255; c++) if ((64'(v) << 30) >= enc_limit[c]) n++;
      enc_lut[v] = 8'(n);
    end
  endfunction

  function automatic int unsigned nonzero(logic [7:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  // source sample pair and fraction along one axis
  function automatic void locate_axis(int unsigned d, int unsigned off, int unsigned csz,
                                      int unsigned dsz, int unsigned n, output int unsigned i0,
                                      output int unsigned i1, output int unsigned fr);
    longint unsigned p;
    p = (longint'(off) << 8) + (longint'(d) * nonzero(8'(csz)) * 256) / nonzero(8'(dsz));
    i0 = ((p >> 8) > n - 1) ? n - 1 : int'(p >> 8);
    i1 = (i0 + 1 > n - 1) ? n - 1 : i0 + 1;
    fr = (i1 == i0) ? 0 : int'(p & 255);
  endfunction

  function automatic void neighbors(logic [6:0] x, logic [6:0] y, output int unsigned addr [4],
                                    output int unsigned fx, output int unsigned fy);
    int unsigned sw, sh, x0, x1, y0, y1;
    sw = nonzero(cur_cfg.src_w);
    if (sw > MAX_WIDTH) sw = MAX_WIDTH;
    sh = nonzero(cur_cfg.src_h);
    if (sh > MAX_HEIGHT) sh = MAX_HEIGHT;
    locate_axis(x, cur_cfg.crop_x & 8'h7f, cur_cfg.crop_w, cur_cfg.dst_w, sw, x0, x1, fx);
    locate_axis(y, cur_cfg.crop_y & 8'h7f, cur_cfg.crop_h, cur_cfg.dst_h, sh, y0, y1, fy);
    addr[0] = y0 * MAX_WIDTH + x0;
    addr[1] = y0 * MAX_WIDTH + x1;
    addr[2] = y1 * MAX_WIDTH + x0;
    addr[3] = y1 * MAX_WIDTH + x1;
  endfunction

  function automatic int unsigned mix(int unsigned a00, int unsigned a10, int unsigned a01,
                                      int unsigned a11, int unsigned fx, int unsigned fy);
    return (a00 * (256 - fx) + a10 * fx) * (256 - fy) + (a01 * (256 - fx) + a11 * fx) * fy;
  endfunction

  function automatic pixel_t resample(logic [6:0] x, logic [6:0] y);
    int unsigned addr [4];
    int unsigned fx, fy;
    pixel_t q [4];
    pixel_t r;
    neighbors(x, y, addr, fx, fy);
    for (int k = 0; k < 4; k++) q[k] = frame_copy[addr[k]];
    r.red = enc_lut[(mix(lin_lut[q[0].red], lin_lut[q[1].red], lin_lut[q[2].red],
                         lin_lut[q[3].red], fx, fy) + 32768) >> 16];
    r.green = enc_lut[(mix(lin_lut[q[0].green], lin_lut[q[1].green], lin_lut[q[2].green],
                           lin_lut[q[3].green], fx, fy) + 32768) >> 16];
    r.blue = enc_lut[(mix(lin_lut[q[0].blue], lin_lut[q[1].blue], lin_lut[q[2].blue],
                          lin_lut[q[3].blue], fx, fy) + 32768) >> 16];
    r.alpha = 8'(mix(q[0].alpha, q[1].alpha, q[2].alpha, q[3].alpha, fx, fy) >> 16);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // drive one word and wait for the accept, then update the predictor
  task automatic send_word(logic op, logic [6:0] x, logic [6:0] y, pixel_t pix,
                           bit typed = 0, pixel_t want = '0);
    while (idle_in > 0 && $urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    pos_x_i     <= x;
    pos_y_i     <= y;
    in_red_i    <= pix.red;
    in_green_i  <= pix.green;
    in_blue_i   <= pix.blue;
    in_alpha_i  <= pix.alpha;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (op == OP_LOAD) begin
      frame_copy[y * MAX_WIDTH + x] = pix;
      loaded[y * MAX_WIDTH + x] = 1;
    end else begin
      pending_pixels.push_back(typed ? want : resample(x, y));
    end
  endtask

  // compute word, with loads first for any sample never written
  task automatic compute_safe(logic [6:0] x, logic [6:0] y);
    int unsigned addr [4];
    int unsigned fx, fy;
    neighbors(x, y, addr, fx, fy);
    for (int k = 0; k < 4; k++)
      if (!loaded[addr[k]])
        send_word(OP_LOAD, 7'(addr[k] % MAX_WIDTH), 7'(addr[k] / MAX_WIDTH), $urandom);
    send_word(OP_COMPUTE, x, y, $urandom);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_cfg(scaler_cfg_t c);
    logic [7:0] vals [8];
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    vals = '{c.src_w, c.src_h, c.crop_x, c.crop_y, c.crop_w, c.crop_h, c.dst_w, c.dst_h};
    for (int k = 0; k < 8; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 3'(k);
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  // result side: random stall, compare, watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        got_exp = pending_pixels.pop_front();
        if (out_red_o !== got_exp.red || out_green_o !== got_exp.green ||
            out_blue_o !== got_exp.blue || out_alpha_o !== got_exp.alpha)
          report_mismatch($sformatf("rgba got %h %h %h %h want %h %h %h %h",
            out_red_o, out_green_o, out_blue_o, out_alpha_o,
            got_exp.red, got_exp.green, got_exp.blue, got_exp.alpha));
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    out_ready_i <= ($urandom_range(99) >= idle_out);
  end

  localparam pixel_t WHITE = 32'hffffffff;
  localparam pixel_t BLACK = 32'h00000000;

  row_t directed [] = '{
    '{OP_LOAD, 7'd0, 7'd0, WHITE, 0, BLACK},
    '{OP_LOAD, 7'd1, 7'd0, WHITE, 0, BLACK},
    '{OP_LOAD, 7'd0, 7'd1, WHITE, 0, BLACK},
    '{OP_LOAD, 7'd1, 7'd1, WHITE, 0, BLACK},
    '{OP_COMPUTE, 7'd0, 7'd0, BLACK, 1, WHITE},
    '{OP_LOAD, 7'd126, 7'd127, BLACK, 0, BLACK},
    '{OP_LOAD, 7'd127, 7'd127, BLACK, 0, BLACK},
    '{OP_COMPUTE, 7'd127, 7'd127, WHITE, 1, BLACK},
    '{OP_LOAD, 7'd126, 7'd126, 32'h8040c07f, 0, BLACK},
    '{OP_LOAD, 7'd127, 7'd126, 32'h01fe55aa, 0, BLACK},
    '{OP_COMPUTE, 7'd126, 7'd126, 32'h5a5a5a5a, 0, BLACK},
    '{OP_COMPUTE, 7'd127, 7'd126, WHITE, 0, BLACK}
  };

  // extremes: defaults, scale-up, crop down, all-zero sizes, oversized source, tiny source
  scaler_cfg_t phases [] = '{
    '{8'd128, 8'd128, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128},
    '{8'd128, 8'd128, 8'd0, 8'd0, 8'd7, 8'd5, 8'd128, 8'd100},
    '{8'd100, 8'd90, 8'd20, 8'd10, 8'd60, 8'd70, 8'd17, 8'd23},
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd200, 8'd255, 8'd127, 8'd128, 8'd255, 8'd1, 8'd3},
    '{8'd2, 8'd1, 8'd1, 8'd128, 8'd255, 8'd3, 8'd128, 8'd128},
    '{8'd64, 8'd128, 8'd33, 8'd5, 8'd40, 8'd128, 8'd128, 8'd1},
    '{8'd1, 8'd128, 8'd127, 8'd0, 8'd1, 8'd128, 8'd50, 8'd128}
  };

  initial begin
    int k;
    scaler_cfg_t c;
    build_gamma_luts();
    cur_cfg = phases[0];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i])
      send_word(directed[i].op, directed[i].px, directed[i].py, directed[i].pix,
                directed[i].typed, directed[i].want);
    for (int ph = 0; ph < phases.size() + 2; ph++) begin
      if (ph < phases.size()) begin
        c = phases[ph];
      end else begin
        c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      end
      apply_cfg(c);
      k = 0;
      // every phase gets an equal share of words, fill loads included
      while (sent < 12 + (ph + 1) * 118) begin
        if (sent < 400) begin
          idle_in = 22;
          idle_out = 50;
        end else if (sent < 800) begin
          idle_in = 50;
          idle_out = 22;
        end else begin
          idle_in = 0;
          idle_out = 0;
        end
        if (ph == 1 && k == 20) drain();
        if ($urandom_range(99) < 65) compute_safe(7'($urandom), 7'($urandom));
        else send_word(OP_LOAD, 7'($urandom), 7'($urandom), $urandom);
        k++;
      end
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### files.f
+incdir+design
design/gcbs_pkg.sv
design/gcbs_ram.sv
design/gcbs_div.sv
design/gcbs_ctrl.sv
design/gcbs_dp.sv
design/gamma_correct_bilinear_scaler.sv
bench/tb_top.sv
